[design/lpr_pkg.sv]
// ----------------------------------------------------------------------------
// LRU replacement list package
// Operation codes, cell control struct and stream field layout.
// ----------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_TOUCH  = 2'd1,
        MODE_EVICT  = 2'd2
    } t_mode;

    // per-cell control for one transfer
    typedef struct packed {
        logic upd_insert;   // successful insert this cycle
        logic upd_touch;    // successful touch this cycle
        logic upd_evict;    // successful evict this cycle
        logic in_range;     // cell position below count
        logic is_last;      // cell position equals count - 1
        logic is_append;    // cell position equals count
    } t_cell_ctl;

    localparam int unsigned PAGE_W      = 8;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned S_TDATA_W   = 16;
    localparam int unsigned M_TDATA_W   = 16;

endpackage

`default_nettype wire

[design/lpr_cell.sv]
// ----------------------------------------------------------------------------
// LRU list cell
// Holds one list position; compares against the request and takes its
// right neighbour's page on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_cell
    import lpr_pkg::*;
#(
    parameter int unsigned PAGE_BITS = 8
) (
    input  wire logic                 i_clk,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic [PAGE_BITS-1:0] i_page,       // request page
    input  wire logic [PAGE_BITS-1:0] i_next_page,  // neighbour towards MRU end
    input  wire logic                 i_found,      // hit seen in an earlier cell
    output logic      [PAGE_BITS-1:0] o_page,
    output logic                      o_found
);

    logic [PAGE_BITS-1:0] r_page;
    logic [PAGE_BITS-1:0] n_page;
    logic                 w_match;

    assign w_match = i_ctl.in_range && (r_page == i_page);
    assign o_found = i_found || w_match;
    assign o_page  = r_page;

    always_comb begin
        n_page = r_page;
        if (i_ctl.upd_insert && i_ctl.is_append) begin
            n_page = i_page;
        end else if (i_ctl.upd_touch) begin
            // at or behind the first hit: close the gap, tail gets the page
            if (i_ctl.is_last) begin
                n_page = i_page;
            end else if (i_ctl.in_range && o_found) begin
                n_page = i_next_page;
            end
        end else if (i_ctl.upd_evict && i_ctl.in_range) begin
            n_page = i_next_page;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
    end

endmodule

`default_nettype wire

[design/lru_page_replacement_queue.sv]
// ----------------------------------------------------------------------------
// LRU page replacement list
// Row of compare-and-shift cells, cell 0 least recent, with a registered
// result stage on the output stream.
// ----------------------------------------------------------------------------
//  channel   direction  tdata fields (low bit up)
//  s_axis    in         mode[1:0], page[9:2], zero pad
//  m_axis    out        evicted_page[7:0], evicted_valid[8], error[9],
//                       full_res[10], count[14:11], zero pad
//
//  One transfer per cycle unless the output stalls: the cell row and the
//  output register both update on the accepting edge. The first-hit search
//  ripples through the row of DEPTH cells within the accepting cycle.
//  Input is taken whenever the output register is empty or being drained.
//  Synchronous active-low reset empties the list; slot contents are not
//  cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement_queue
    import lpr_pkg::*;
#(
    parameter int unsigned DEPTH     = 8,
    parameter int unsigned PAGE_BITS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,  // mode, page
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic      [M_TDATA_W-1:0] o_m_axis_tdata   // page, valid, error, full, count
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;
    logic [M_TDATA_W-1:0] n_m_data;

    logic                 w_accept;
    logic [MODE_W-1:0]    w_mode;
    logic [PAGE_W-1:0]    w_page_in;
    logic [PAGE_BITS-1:0] w_page;
    logic                 w_ins_ok;
    logic                 w_touch_ok;
    logic                 w_evict_ok;
    logic                 w_error;
    logic [PAGE_W-1:0]    w_evicted;
    logic [COUNT_W-1:0]   w_count_out;

    logic [PAGE_BITS-1:0] w_cell_page [DEPTH];
    logic [PAGE_BITS-1:0] w_next_page [DEPTH];
    logic [DEPTH:0]       w_found;
    t_cell_ctl            w_ctl       [DEPTH];

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_mode    = i_s_axis_tdata[MODE_W-1:0];
    assign w_page_in = i_s_axis_tdata[MODE_W +: PAGE_W];
    assign w_page    = PAGE_BITS'(32'(w_page_in));

    // success per operation; a failed request leaves the list alone
    always_comb begin
        w_ins_ok   = 1'b0;
        w_touch_ok = 1'b0;
        w_evict_ok = 1'b0;
        unique case (t_mode'(w_mode))
            MODE_INSERT: w_ins_ok   = (r_count < CNT_W'(DEPTH));
            MODE_TOUCH:  w_touch_ok = w_found[DEPTH];
            MODE_EVICT:  w_evict_ok = (r_count != '0);
            default: ;
        endcase
    end

    assign w_error = !(w_ins_ok || w_touch_ok || w_evict_ok);

    assign w_found[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == DEPTH - 1) begin : g_end
                assign w_next_page[g] = '0;
            end else begin : g_mid
                assign w_next_page[g] = w_cell_page[g+1];
            end

            always_comb begin
                w_ctl[g].upd_insert = w_accept && w_ins_ok;
                w_ctl[g].upd_touch  = w_accept && w_touch_ok;
                w_ctl[g].upd_evict  = w_accept && w_evict_ok;
                w_ctl[g].in_range   = (CNT_W'(g) < r_count);
                w_ctl[g].is_last    = (CNT_W'(g + 1) == r_count);
                w_ctl[g].is_append  = (CNT_W'(g) == r_count);
            end

            lpr_cell #(
                .PAGE_BITS (PAGE_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl[g]),
                .i_page      (w_page),
                .i_next_page (w_next_page[g]),
                .i_found     (w_found[g]),
                .o_page      (w_cell_page[g]),
                .o_found     (w_found[g+1])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ins_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_evict_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_evicted   = w_evict_ok ? PAGE_W'(32'(w_cell_page[0])) : '0;
    assign w_count_out = COUNT_W'(32'(n_count));

    always_comb begin
        n_m_data       = '0;
        n_m_data[7:0]  = w_evicted;
        n_m_data[8]    = w_evict_ok;
        n_m_data[9]    = w_error;
        n_m_data[10]   = (n_count == CNT_W'(DEPTH));
        n_m_data[14:11] = w_count_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_data <= n_m_data;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

[dv/tb_lru_page_replacement_queue.sv]
// ----------------------------------------------------------------------------
// LRU page replacement list testbench
// Drives insert, touch, evict and undefined-mode transfers into the stream
// input and predicts each result from a local copy of the recency order. A
// scoreboard matches every output transfer field by field against the oldest
// prediction. Both ports idle in random bursts, and one long output stall
// backs the list up.
// ----------------------------------------------------------------------------

module tb_lru_page_replacement_queue;
    import lpr_pkg::*;

    localparam int unsigned LRU_DEPTH   = 8;
    localparam int unsigned RAND_ITEMS  = 1900;
    localparam int unsigned SEG_ITEMS   = 100;
    localparam int unsigned QUIET_SEGS  = 3;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned HOLD_AFTER  = 400;
    localparam int unsigned WATCHDOG    = 3000;
    localparam logic [1:0]  MODE_BAD    = 2'd3;

    // evicted_page[7:0], evicted_valid[8], error[9], full_res[10], count[14:11]
    typedef struct packed {
        logic [3:0] count;
        logic       full_res;
        logic       error;
        logic       evicted_valid;
        logic [7:0] evicted_page;
    } t_lru_result;

    class lru_scoreboard;
        logic [7:0]  held_pages[$];     // index 0 is least recent
        t_lru_result expected_q[$];
        int unsigned mismatches = 0;
        int unsigned checked    = 0;
        int unsigned noted      = 0;
        int unsigned n_evicts   = 0;
        int unsigned n_hits     = 0;
        int unsigned n_errors   = 0;

        function void note_input(logic [1:0] mode, logic [7:0] page);
            t_lru_result res;
            int          hit;
            res = '0;
            hit = -1;
            case (mode)
                MODE_INSERT: begin
                    if (held_pages.size() < LRU_DEPTH) held_pages.push_back(page);
                    else res.error = 1'b1;
                end
                MODE_TOUCH: begin
                    for (int i = 0; i < held_pages.size(); i++) begin
                        if (hit < 0 && held_pages[i] == page) hit = i;
                    end
                    if (hit >= 0) begin
                        held_pages.delete(hit);
                        held_pages.push_back(page);
                        n_hits++;
                    end else begin
                        res.error = 1'b1;
                    end
                end
                MODE_EVICT: begin
                    if (held_pages.size() > 0) begin
                        res.evicted_page  = held_pages.pop_front();
                        res.evicted_valid = 1'b1;
                        n_evicts++;
                    end else begin
                        res.error = 1'b1;
                    end
                end
                default: res.error = 1'b1;
            endcase
            res.count    = 4'(held_pages.size());
            res.full_res = (held_pages.size() == LRU_DEPTH);
            if (res.error) n_errors++;
            expected_q.push_back(res);
            noted++;
        endfunction

        task report_mismatch(string what, int unsigned got_v, int unsigned want_v);
            $display("MISMATCH result %0d %s: got 0x%0h, want 0x%0h",
                     checked, what, got_v, want_v);
            mismatches++;
        endtask

        task check_result(logic [M_TDATA_W-1:0] tdata);
            t_lru_result got;
            t_lru_result want;
            got = tdata[14:0];
            checked++;
            if (expected_q.size() == 0) begin
                report_mismatch("with nothing outstanding", got, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.evicted_page !== want.evicted_page)
                report_mismatch("evicted_page", got.evicted_page, want.evicted_page);
            if (got.evicted_valid !== want.evicted_valid)
                report_mismatch("evicted_valid", got.evicted_valid, want.evicted_valid);
            if (got.error !== want.error)
                report_mismatch("error", got.error, want.error);
            if (got.full_res !== want.full_res)
                report_mismatch("full_res", got.full_res, want.full_res);
            if (got.count !== want.count)
                report_mismatch("count", got.count, want.count);
        endtask

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata  = '0;   // mode[1:0], page[9:2], zero pad
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;         // page, valid, error, full, count

    lru_scoreboard sb;
    bit            idle_on       = 1'b1;
    bit            pressure_done = 1'b0;

    lru_page_replacement_queue #(
        .DEPTH     (LRU_DEPTH),
        .PAGE_BITS (PAGE_W)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // offer one transfer, optionally after an idle burst, and hold until taken
    task send_page_op(logic [1:0] mode, logic [7:0] page);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= 16'($urandom);
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'b0, page, mode};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(mode, page);
    endtask

    // mix biased by occupancy so that full, empty and hit cases all recur
    task send_random_op();
        int unsigned n;
        int unsigned r;
        logic [1:0]  mode;
        logic [7:0]  page;
        n    = sb.held_pages.size();
        r    = $urandom_range(0, 99);
        page = 8'($urandom_range(0, 255));
        if (r < 3)
            mode = MODE_BAD;
        else if (n == 0)
            mode = (r < 80) ? MODE_INSERT : ((r < 90) ? MODE_TOUCH : MODE_EVICT);
        else if (n == LRU_DEPTH)
            mode = (r < 12) ? MODE_INSERT : ((r < 60) ? MODE_TOUCH : MODE_EVICT);
        else
            mode = (r < 43) ? MODE_INSERT : ((r < 78) ? MODE_TOUCH : MODE_EVICT);
        r = $urandom_range(0, 99);
        if (mode == MODE_TOUCH && n > 0 && r < 75) begin
            page = sb.held_pages[$urandom_range(0, n - 1)];
        end else if (mode == MODE_INSERT) begin
            // small pool and copies of held pages give plenty of duplicates
            if (r < 30)                 page = 8'($urandom_range(0, 7));
            else if (r < 50 && n > 0)   page = sb.held_pages[$urandom_range(0, n - 1)];
        end
        send_page_op(mode, page);
    endtask

    // output side: random stall bursts plus one long hold to back the list up
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!pressure_done && sb.checked >= HOLD_AFTER) begin
                i_m_axis_tready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge i_clk);
                pressure_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready) sb.check_result(o_m_axis_tdata);
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG);
        $display("lru_page_replacement_queue regression: fail");
        $finish;
    end

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-list errors, duplicates, fill past full, drain past empty
        send_page_op(MODE_EVICT,  8'h00);
        send_page_op(MODE_TOUCH,  8'h00);
        send_page_op(MODE_BAD,    8'hFF);
        send_page_op(MODE_INSERT, 8'h00);
        send_page_op(MODE_INSERT, 8'hFF);
        send_page_op(MODE_INSERT, 8'h00);
        send_page_op(MODE_TOUCH,  8'h00);   // only the older copy moves
        send_page_op(MODE_TOUCH,  8'h12);
        send_page_op(MODE_INSERT, 8'hAA);
        send_page_op(MODE_INSERT, 8'h55);
        send_page_op(MODE_INSERT, 8'h01);
        send_page_op(MODE_INSERT, 8'h80);
        send_page_op(MODE_INSERT, 8'h7F);
        send_page_op(MODE_INSERT, 8'h33);   // list full
        send_page_op(MODE_TOUCH,  8'hFF);
        send_page_op(MODE_BAD,    8'h00);
        send_page_op(MODE_TOUCH,  8'h7F);   // second most recent, just behind 8'hFF
        repeat (LRU_DEPTH) send_page_op(MODE_EVICT, 8'hFF);
        send_page_op(MODE_EVICT,  8'h5A);

        for (int s = 0; s < RAND_ITEMS / SEG_ITEMS; s++) begin
            if (s >= RAND_ITEMS / SEG_ITEMS - QUIET_SEGS) idle_on = 1'b0;
            else idle_on = ($urandom_range(0, 4) != 0);
            repeat (SEG_ITEMS) send_random_op();
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("covered %0d input transfers, %0d results: %0d evicts, %0d touch hits, %0d errors",
                 sb.noted, sb.checked, sb.n_evicts, sb.n_hits, sb.n_errors);
        $display("idle bursts on both ports and one %0d-cycle output hold; %0d mismatches",
                 HOLD_CYCLES, sb.mismatches);
        if (sb.mismatches == 0)
            $display("lru_page_replacement_queue regression: pass");
        else
            $display("lru_page_replacement_queue regression: fail");
        $finish;
    end

endmodule
